// ===== design/assert_macros.svh =====
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define SCG_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define SCG_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// When the antecedent holds, the consequent must hold in the following cycle.
`define SCG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/scg_pkg.sv =====
`default_nettype none

package scg_pkg;

   // Capacity of the block.
   localparam int MAX_JOINTS = 8;
   localparam int MAX_STEPS  = 1024;

   // Index widths and widths of counts that can hold the maximum itself.
   localparam int JOINT_W = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
   localparam int STEP_W  = $clog2(MAX_STEPS);
   localparam int JCNT_W  = $clog2(MAX_JOINTS + 1);
   localparam int SCNT_W  = $clog2(MAX_STEPS + 1);

   // Configuration port.
   localparam int CFG_JOINTS_W = 4;
   localparam int CFG_STEPS_W  = 11;
   localparam int CSR_DATA_W   = 11;
   localparam int CSR_INDEX_W  = 1;

   localparam logic [CFG_JOINTS_W-1:0] JOINTS_RESET = 4'd7;
   localparam logic [CFG_STEPS_W-1:0]  STEPS_RESET  = 11'd2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_NUM_JOINTS = 1'b0,
      CSR_NUM_STEPS  = 1'b1
   } csr_index_type;

   // Datapath widths.
   localparam int POS_W   = 32;
   localparam int RES_W   = 35;
   localparam int MAG_W   = RES_W - 1;
   localparam int HALF_W  = 17;
   localparam int HIGH_W  = MAG_W - HALF_W;
   localparam int PROD_W  = 2 * HALF_W;
   localparam int Q_SHIFT = 16;
   localparam int HH_SHIFT = 2 * HALF_W - Q_SHIFT;
   localparam int HL_SHIFT = HALF_W + 1 - Q_SHIFT;
   localparam int SQ_W    = 2 * MAG_W - Q_SHIFT + 1;
   localparam int COST_W  = 63;
   localparam int GRAD_W  = 37;

   typedef enum logic [1:0] {
      MUL_HH,
      MUL_HL,
      MUL_LL
   } mul_phase_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_HH,
      ST_MUL_HL,
      ST_MUL_LL,
      ST_ACC,
      ST_OWN,
      ST_END,
      ST_FLUSH_PREV,
      ST_FLUSH_TAIL,
      ST_COST
   } ctrl_state_type;

   typedef struct packed {
      logic          load;
      logic          mul_en;
      mul_phase_type mul_phase;
      logic          acc;
      logic          emit_own;
      logic          emit_prev;
      logic          emit_tail;
      logic          emit_cost;
      logic          k_step;
      logic          advance;
      logic          clear;
   } dp_cmd_type;

   typedef struct packed {
      logic t_ge1;
      logic t_ge2;
      logic last_item;
      logic k_last;
      logic out_free;
   } dp_status_type;

   function automatic logic [JCNT_W-1:0] clamp_joints(input logic [CFG_JOINTS_W-1:0] raw);
      logic [JCNT_W-1:0] res;
      if (raw == '0) begin
         res = JCNT_W'(1);
      end else if (int'(raw) > MAX_JOINTS) begin
         res = JCNT_W'(MAX_JOINTS);
      end else begin
         res = JCNT_W'(raw);
      end
      return res;
   endfunction

   function automatic logic [SCNT_W-1:0] clamp_steps(input logic [CFG_STEPS_W-1:0] raw);
      logic [SCNT_W-1:0] res;
      if (raw == '0) begin
         res = SCNT_W'(1);
      end else if (int'(raw) > MAX_STEPS) begin
         res = SCNT_W'(MAX_STEPS);
      end else begin
         res = SCNT_W'(raw);
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== design/scg_ctrl.sv =====
`default_nettype none

module scg_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire scg_pkg::dp_status_type status,
   output scg_pkg::dp_cmd_type        cmd
);

   scg_pkg::ctrl_state_type state_ff;
   scg_pkg::ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= scg_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         scg_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = scg_pkg::ST_MUL_HH;
            end
         end
         scg_pkg::ST_MUL_HH: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_phase = scg_pkg::MUL_HH;
            state_in      = scg_pkg::ST_MUL_HL;
         end
         scg_pkg::ST_MUL_HL: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_phase = scg_pkg::MUL_HL;
            state_in      = scg_pkg::ST_MUL_LL;
         end
         scg_pkg::ST_MUL_LL: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_phase = scg_pkg::MUL_LL;
            state_in      = scg_pkg::ST_ACC;
         end
         scg_pkg::ST_ACC: begin
            cmd.acc  = 1'b1;
            state_in = status.t_ge2 ? scg_pkg::ST_OWN : scg_pkg::ST_END;
         end
         scg_pkg::ST_OWN: begin
            if (status.out_free) begin
               cmd.emit_own = 1'b1;
               state_in     = scg_pkg::ST_END;
            end
         end
         scg_pkg::ST_END: begin
            if (status.last_item) begin
               state_in = status.t_ge1 ? scg_pkg::ST_FLUSH_PREV : scg_pkg::ST_FLUSH_TAIL;
            end else begin
               cmd.advance = 1'b1;
               state_in    = scg_pkg::ST_IDLE;
            end
         end
         scg_pkg::ST_FLUSH_PREV: begin
            if (status.out_free) begin
               cmd.emit_prev = 1'b1;
               cmd.k_step    = 1'b1;
               if (status.k_last) begin
                  state_in = scg_pkg::ST_FLUSH_TAIL;
               end
            end
         end
         scg_pkg::ST_FLUSH_TAIL: begin
            if (status.out_free) begin
               cmd.emit_tail = 1'b1;
               cmd.k_step    = 1'b1;
               if (status.k_last) begin
                  state_in = scg_pkg::ST_COST;
               end
            end
         end
         scg_pkg::ST_COST: begin
            if (status.out_free) begin
               cmd.emit_cost = 1'b1;
               cmd.clear     = 1'b1;
               state_in      = scg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = scg_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== design/scg_dpath.sv =====
`default_nettype none

module scg_dpath (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire scg_pkg::dp_cmd_type                     cmd,
   output scg_pkg::dp_status_type                       status,
   input  wire logic                                    csr_write_enable,
   input  wire logic [scg_pkg::CSR_INDEX_W-1:0]         csr_index,
   input  wire logic [scg_pkg::CSR_DATA_W-1:0]          csr_write_data,
   input  wire logic signed [scg_pkg::POS_W-1:0]        req_position,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_ready,
   output logic                                         rsp_is_cost,
   output logic [scg_pkg::STEP_W-1:0]                   rsp_step_index,
   output logic [scg_pkg::JOINT_W-1:0]                  rsp_joint_index,
   output logic signed [scg_pkg::GRAD_W-1:0]            rsp_gradient_value,
   output logic [scg_pkg::COST_W-1:0]                   rsp_cost_value,
   output logic                                         rsp_last
);

   localparam int GW = scg_pkg::GRAD_W + 1;

   // Configuration, held in its effective (clamped) form.
   logic [scg_pkg::JCNT_W-1:0] nj_ff, nj_in;
   logic [scg_pkg::SCNT_W-1:0] ns_ff, ns_in;

   // Position counters and flush index.
   logic [scg_pkg::STEP_W-1:0]  t_ff, t_in;
   logic [scg_pkg::JOINT_W-1:0] j_ff, j_in;
   logic [scg_pkg::JOINT_W-1:0] k_ff, k_in;

   // Per-joint history.
   logic signed [scg_pkg::POS_W-1:0] pos1_ff [scg_pkg::MAX_JOINTS];
   logic signed [scg_pkg::POS_W-1:0] pos2_ff [scg_pkg::MAX_JOINTS];
   logic signed [scg_pkg::RES_W-1:0] res1_ff [scg_pkg::MAX_JOINTS];
   logic signed [scg_pkg::RES_W-1:0] res2_ff [scg_pkg::MAX_JOINTS];
   logic signed [scg_pkg::POS_W-1:0] pos1_in [scg_pkg::MAX_JOINTS];
   logic signed [scg_pkg::POS_W-1:0] pos2_in [scg_pkg::MAX_JOINTS];
   logic signed [scg_pkg::RES_W-1:0] res1_in [scg_pkg::MAX_JOINTS];
   logic signed [scg_pkg::RES_W-1:0] res2_in [scg_pkg::MAX_JOINTS];

   // Working registers of the item in flight.
   logic signed [scg_pkg::POS_W-1:0] x_ff, x_in;
   logic signed [scg_pkg::POS_W-1:0] p1_ff, p1_in;
   logic signed [scg_pkg::RES_W-1:0] q1_ff, q1_in;
   logic signed [scg_pkg::RES_W-1:0] q2_ff, q2_in;
   logic signed [scg_pkg::RES_W-1:0] r_ff, r_in;
   logic [scg_pkg::SQ_W-1:0]         sq_ff, sq_in;
   logic [scg_pkg::COST_W-1:0]       cost_ff, cost_in;

   // Result register.
   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               rsp_is_cost_ff, rsp_is_cost_in;
   logic [scg_pkg::STEP_W-1:0]         rsp_step_ff, rsp_step_in;
   logic [scg_pkg::JOINT_W-1:0]        rsp_joint_ff, rsp_joint_in;
   logic signed [scg_pkg::GRAD_W-1:0]  rsp_grad_ff, rsp_grad_in;
   logic [scg_pkg::COST_W-1:0]         rsp_cost_ff, rsp_cost_in;
   logic                               rsp_last_ff, rsp_last_in;

   logic [scg_pkg::JOINT_W-1:0]        rd_idx;
   logic signed [scg_pkg::RES_W-1:0]   p1_ext, p2_ext, x_ext, r_calc;
   logic [scg_pkg::MAG_W-1:0]          mag;
   logic [scg_pkg::HALF_W-1:0]         mul_a, mul_b;
   logic [scg_pkg::PROD_W-1:0]         prod;
   logic [scg_pkg::COST_W:0]           cost_sum;
   logic signed [GW-1:0]               rg, q1g, q2g, ag, bg, g_own, g_prev, g_tail;
   logic                               t_is1, t_is2, last_joint, last_step, clear_all;
   logic                               emit_any;

   assign clear_all  = cmd.clear || csr_write_enable;
   assign rd_idx     = cmd.load ? j_ff : k_ff;
   assign t_is1      = t_ff == scg_pkg::STEP_W'(1);
   assign t_is2      = t_ff == scg_pkg::STEP_W'(2);
   assign last_joint = (scg_pkg::JCNT_W'(j_ff) + scg_pkg::JCNT_W'(1)) == nj_ff;
   assign last_step  = (scg_pkg::SCNT_W'(t_ff) + scg_pkg::SCNT_W'(1)) == ns_ff;
   assign emit_any   = cmd.emit_own || cmd.emit_prev || cmd.emit_tail || cmd.emit_cost;

   assign status.t_ge1     = t_ff != '0;
   assign status.t_ge2     = (t_ff != '0) && !t_is1;
   assign status.last_item = last_joint && last_step;
   assign status.k_last    = (scg_pkg::JCNT_W'(k_ff) + scg_pkg::JCNT_W'(1)) == nj_ff;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   // Residual of the incoming sample.
   assign x_ext  = scg_pkg::RES_W'(req_position);
   assign p1_ext = scg_pkg::RES_W'(pos1_ff[rd_idx]);
   assign p2_ext = scg_pkg::RES_W'(pos2_ff[rd_idx]);

   always_comb begin
      if (t_ff == '0) begin
         r_calc = '0;
      end else if (t_is1) begin
         r_calc = x_ext - p1_ext;
      end else begin
         r_calc = x_ext - (p1_ext <<< 1) + p2_ext;
      end
   end

   // Square of the residual through one 17 by 17 multiplier in three passes.
   assign mag   = r_ff[scg_pkg::RES_W-1] ? scg_pkg::MAG_W'(-r_ff) : scg_pkg::MAG_W'(r_ff);
   assign mul_a = (cmd.mul_phase == scg_pkg::MUL_LL) ? mag[scg_pkg::HALF_W-1:0]
                                                     : scg_pkg::HALF_W'(mag[scg_pkg::MAG_W-1:scg_pkg::HALF_W]);
   assign mul_b = (cmd.mul_phase == scg_pkg::MUL_HH) ? scg_pkg::HALF_W'(mag[scg_pkg::MAG_W-1:scg_pkg::HALF_W])
                                                     : mag[scg_pkg::HALF_W-1:0];
   assign prod  = scg_pkg::PROD_W'(mul_a) * scg_pkg::PROD_W'(mul_b);

   always_comb begin
      unique case (cmd.mul_phase)
         scg_pkg::MUL_HH: sq_in = scg_pkg::SQ_W'(prod) << scg_pkg::HH_SHIFT;
         scg_pkg::MUL_HL: sq_in = sq_ff + (scg_pkg::SQ_W'(prod) << scg_pkg::HL_SHIFT);
         scg_pkg::MUL_LL: sq_in = sq_ff + scg_pkg::SQ_W'(prod >> scg_pkg::Q_SHIFT);
         default:         sq_in = sq_ff;
      endcase
      if (!cmd.mul_en) begin
         sq_in = sq_ff;
      end
   end

   assign cost_sum = {1'b0, cost_ff} + (scg_pkg::COST_W + 1)'(sq_ff);

   // Gradients.
   assign rg  = GW'(r_ff);
   assign q1g = GW'(q1_ff);
   assign q2g = GW'(q2_ff);
   assign ag  = GW'(res2_ff[rd_idx]);
   assign bg  = GW'(res1_ff[rd_idx]);

   assign g_own  = t_is2 ? ((rg - q1g) <<< 1) : ((q2g - (q1g <<< 1) + rg) <<< 1);
   assign g_prev = t_is1 ? -(bg <<< 1) : ((ag - (bg <<< 1)) <<< 1);
   assign g_tail = (t_ff != '0) ? (bg <<< 1) : '0;

   always_comb begin
      nj_in   = nj_ff;
      ns_in   = ns_ff;
      t_in    = t_ff;
      j_in    = j_ff;
      k_in    = k_ff;
      x_in    = x_ff;
      p1_in   = p1_ff;
      q1_in   = q1_ff;
      q2_in   = q2_ff;
      r_in    = r_ff;
      cost_in = cost_ff;
      pos1_in = pos1_ff;
      pos2_in = pos2_ff;
      res1_in = res1_ff;
      res2_in = res2_ff;

      if (csr_write_enable) begin
         unique case (scg_pkg::csr_index_type'(csr_index))
            scg_pkg::CSR_NUM_JOINTS:
               nj_in = scg_pkg::clamp_joints(csr_write_data[scg_pkg::CFG_JOINTS_W-1:0]);
            scg_pkg::CSR_NUM_STEPS:
               ns_in = scg_pkg::clamp_steps(csr_write_data[scg_pkg::CFG_STEPS_W-1:0]);
         endcase
      end

      if (cmd.load) begin
         x_in  = req_position;
         p1_in = pos1_ff[rd_idx];
         q1_in = res1_ff[rd_idx];
         q2_in = res2_ff[rd_idx];
         r_in  = r_calc;
      end

      if (cmd.acc) begin
         cost_in = cost_sum[scg_pkg::COST_W] ? '1 : cost_sum[scg_pkg::COST_W-1:0];
         pos2_in[j_ff] = p1_ff;
         pos1_in[j_ff] = x_ff;
         res2_in[j_ff] = q1_ff;
         res1_in[j_ff] = r_ff;
      end

      if (cmd.advance) begin
         if (last_joint) begin
            j_in = '0;
            t_in = t_ff + scg_pkg::STEP_W'(1);
         end else begin
            j_in = j_ff + scg_pkg::JOINT_W'(1);
         end
      end

      if (cmd.k_step) begin
         k_in = status.k_last ? '0 : k_ff + scg_pkg::JOINT_W'(1);
      end

      if (clear_all) begin
         t_in    = '0;
         j_in    = '0;
         k_in    = '0;
         cost_in = '0;
         for (int i = 0; i < scg_pkg::MAX_JOINTS; i++) begin
            pos1_in[i] = '0;
            pos2_in[i] = '0;
            res1_in[i] = '0;
            res2_in[i] = '0;
         end
      end
   end

   // Result register: loads on a command, empties on a transfer.
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_is_cost_in = rsp_is_cost_ff;
      rsp_step_in    = rsp_step_ff;
      rsp_joint_in   = rsp_joint_ff;
      rsp_grad_in    = rsp_grad_ff;
      rsp_cost_in    = rsp_cost_ff;
      rsp_last_in    = rsp_last_ff;
      if (emit_any) begin
         rsp_valid_in   = 1'b1;
         rsp_is_cost_in = cmd.emit_cost;
         rsp_last_in    = cmd.emit_cost;
         rsp_cost_in    = cmd.emit_cost ? cost_ff : '0;
         rsp_joint_in   = k_ff;
         rsp_step_in    = t_ff;
         rsp_grad_in    = '0;
         unique if (cmd.emit_own) begin
            rsp_step_in  = t_ff - scg_pkg::STEP_W'(2);
            rsp_joint_in = j_ff;
            rsp_grad_in  = g_own[scg_pkg::GRAD_W-1:0];
         end else if (cmd.emit_prev) begin
            rsp_step_in = t_ff - scg_pkg::STEP_W'(1);
            rsp_grad_in = g_prev[scg_pkg::GRAD_W-1:0];
         end else if (cmd.emit_tail) begin
            rsp_grad_in = g_tail[scg_pkg::GRAD_W-1:0];
         end else begin
            rsp_step_in  = '0;
            rsp_joint_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nj_ff        <= scg_pkg::clamp_joints(scg_pkg::JOINTS_RESET);
         ns_ff        <= scg_pkg::clamp_steps(scg_pkg::STEPS_RESET);
         t_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         cost_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < scg_pkg::MAX_JOINTS; i++) begin
            pos1_ff[i] <= '0;
            pos2_ff[i] <= '0;
            res1_ff[i] <= '0;
            res2_ff[i] <= '0;
         end
      end else begin
         nj_ff        <= nj_in;
         ns_ff        <= ns_in;
         t_ff         <= t_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         cost_ff      <= cost_in;
         rsp_valid_ff <= rsp_valid_in;
         pos1_ff      <= pos1_in;
         pos2_ff      <= pos2_in;
         res1_ff      <= res1_in;
         res2_ff      <= res2_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff           <= x_in;
      p1_ff          <= p1_in;
      q1_ff          <= q1_in;
      q2_ff          <= q2_in;
      r_ff           <= r_in;
      sq_ff          <= sq_in;
      rsp_is_cost_ff <= rsp_is_cost_in;
      rsp_step_ff    <= rsp_step_in;
      rsp_joint_ff   <= rsp_joint_in;
      rsp_grad_ff    <= rsp_grad_in;
      rsp_cost_ff    <= rsp_cost_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_is_cost        = rsp_is_cost_ff;
   assign rsp_step_index     = rsp_step_ff;
   assign rsp_joint_index    = rsp_joint_ff;
   assign rsp_gradient_value = rsp_grad_ff;
   assign rsp_cost_value     = rsp_cost_ff;
   assign rsp_last           = rsp_last_ff;

endmodule

`default_nettype wire

// ===== design/smoothness_cost_gradient_top.sv =====
// Smoothness cost and gradient of a joint trajectory. Position samples arrive
// in signed Q16.16, time-major and joint-minor, one per transfer on the req_
// channel; for each joint the block forms second-difference residuals, adds
// their squares (rescaled to Q16.16, saturating at 2^63 - 1) into a cost, and
// sends gradient elements on the rsp_ channel, each sample from step 2 on
// releasing the gradient of its joint two steps back. The final sample of a
// trajectory also releases steps T-2 and T-1 for every joint and then the
// cost, marked with last, after which a new trajectory begins. Joint and step
// counts are set through the csr_ port; the user must write them only while
// the block is idle, as the block itself does not enforce it; any write
// restarts the trajectory. Each sample is squared in three passes through one
// 17 by 17 multiplier before the saturating add, and a finished result waits
// while rsp_ready holds it back; the block takes no new sample until it is
// through with the last one.

`default_nettype none

`include "assert_macros.svh"

module smoothness_cost_gradient_top (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    csr_write_enable,
   input  wire logic [scg_pkg::CSR_INDEX_W-1:0]         csr_index,
   input  wire logic [scg_pkg::CSR_DATA_W-1:0]          csr_write_data,
   input  wire logic                                    req_valid,
   output logic                                         req_ready,
   input  wire logic signed [scg_pkg::POS_W-1:0]        req_position,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_ready,
   output logic                                         rsp_is_cost,
   output logic [scg_pkg::STEP_W-1:0]                   rsp_step_index,
   output logic [scg_pkg::JOINT_W-1:0]                  rsp_joint_index,
   output logic signed [scg_pkg::GRAD_W-1:0]            rsp_gradient_value,
   output logic [scg_pkg::COST_W-1:0]                   rsp_cost_value,
   output logic                                         rsp_last
);

   // The controller sequences each sample; the datapath holds the history,
   // the multiplier, the cost and the result register.
   scg_pkg::dp_cmd_type    cmd;
   scg_pkg::dp_status_type status;
   logic                   emit_any;

   scg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   scg_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_position       (req_position),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_is_cost        (rsp_is_cost),
      .rsp_step_index     (rsp_step_index),
      .rsp_joint_index    (rsp_joint_index),
      .rsp_gradient_value (rsp_gradient_value),
      .rsp_cost_value     (rsp_cost_value),
      .rsp_last           (rsp_last)
   );

   assign emit_any = cmd.emit_own || cmd.emit_prev || cmd.emit_tail || cmd.emit_cost;

   // Only one sample is worked on at a time, so a transfer in closes the
   // input for at least the following cycle.
   `SCG_ASSERT_NEXT(a_one_sample_in_flight, clock, reset, req_valid && req_ready, !req_ready, "sample accepted while another is in flight")

   // A result may only be loaded when the result register is empty or is
   // being emptied in the same cycle; otherwise a result would be lost.
   `SCG_ASSERT_SAME(a_emit_has_room, clock, reset, emit_any, status.out_free, "result loaded over a waiting result")

   // The controller never issues two result loads in one cycle.
   `SCG_ASSERT_ALWAYS(a_single_emit, clock, reset, $onehot0({cmd.emit_own, cmd.emit_prev, cmd.emit_tail, cmd.emit_cost}), "more than one result load in a cycle")

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the smoothness cost and gradient block.
//
// A short directed table opens the run: the trajectory that the reset register
// values describe, the extreme positions, joint and step counts of zero, a joint
// count above the capacity, and a trajectory cut short by a register write. Random
// phases follow: several register settings, among them a step count of 2047
// whose trajectory a later write cuts short. Every sample that is accepted is
// fed to a predictor kept in this file. The predictor appends the gradient
// elements and the cost that the sample releases to a queue. Each result
// transfer is compared field by field with the head of that queue.

module testbench;
   import scg_pkg::*;

   // The longest quiet spell in a correct run is the receiver's forced
   // hold-off plus a drain pause. The limit is far above that.
   localparam int WATCHDOG_LIMIT = 2000;
   // A sample that releases nothing can still be in the squaring pipeline
   // when the last awaited result arrives, so wait well beyond the time it needs.
   localparam int DRAIN_CYCLES   = 24;
   localparam int HOLD_CYCLES    = 200;
   localparam int IDLE_PERCENT   = 28;
   localparam logic [63:0] COST_CEILING = 64'h7FFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic                is_cost;
      logic [STEP_W-1:0]   step_index;
      logic [JOINT_W-1:0]  joint_index;
      logic [GRAD_W-1:0]   gradient_value;
      logic [COST_W-1:0]   cost_value;
      logic                last;
   } scg_result_type;

   // A cost typed into the table replaces the predicted one for that sample.
   typedef struct packed {
      logic              typed;
      logic [COST_W-1:0] cost;
   } cost_override_type;

   typedef enum logic {
      ROW_SAMPLE,
      ROW_WRITE
   } row_kind_type;

   typedef struct packed {
      row_kind_type          kind;
      csr_index_type         reg_index;
      logic [CSR_DATA_W-1:0] reg_value;
      logic [POS_W-1:0]      position;
      logic                  typed;
      logic [COST_W-1:0]     typed_cost;
   } stim_row_type;

   // Every input of the block has a known value from time zero onwards.
   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         csr_write_enable = 1'b0;
   csr_index_type                csr_index = CSR_NUM_JOINTS;
   logic [CSR_DATA_W-1:0]        csr_write_data = '0;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic signed [POS_W-1:0]      req_position = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic                         rsp_is_cost;
   logic [STEP_W-1:0]            rsp_step_index;
   logic [JOINT_W-1:0]           rsp_joint_index;
   logic signed [GRAD_W-1:0]     rsp_gradient_value;
   logic [COST_W-1:0]            rsp_cost_value;
   logic                         rsp_last;

   // Predictor state: the register values and one trajectory in progress.
   logic [CFG_JOINTS_W-1:0] cfg_joints;
   logic [CFG_STEPS_W-1:0]  cfg_steps;
   longint                  last_position [MAX_JOINTS];
   longint                  older_position [MAX_JOINTS];
   longint                  last_residual [MAX_JOINTS];
   longint                  older_residual [MAX_JOINTS];
   logic [63:0]             cost_total;
   int                      step_count;
   int                      joint_count;

   scg_result_type    awaited_results [$];
   cost_override_type cost_override_q [$];
   stim_row_type      directed_rows [$];

   // Both sides idle at random unless a calm stretch is running; the driver
   // asks for the long receiver hold-off, which the receiver counts itself.
   bit          calm = 1'b0;
   bit          hold_request = 1'b0;
   int          hold_left = 0;

   int unsigned failures = 0;
   int unsigned samples_taken = 0;
   int unsigned gradients_seen = 0;
   int unsigned costs_seen = 0;
   int unsigned register_writes = 0;

   smoothness_cost_gradient_top i_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_position       (req_position),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_is_cost        (rsp_is_cost),
      .rsp_step_index     (rsp_step_index),
      .rsp_joint_index    (rsp_joint_index),
      .rsp_gradient_value (rsp_gradient_value),
      .rsp_cost_value     (rsp_cost_value),
      .rsp_last           (rsp_last)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   function automatic void clear_model();
      for (int k = 0; k < MAX_JOINTS; k++) begin
         last_position[k]  = 0;
         older_position[k] = 0;
         last_residual[k]  = 0;
         older_residual[k] = 0;
      end
      cost_total  = '0;
      step_count  = 0;
      joint_count = 0;
   endfunction

   // Square of a Q16.16 residual, brought back to Q16.16 by truncation.
   // The residual stays below 2^35 in magnitude, so 80 bits hold the product.
   function automatic logic [63:0] square_q16(input longint r);
      logic [39:0] mag;
      logic [79:0] prod;
      mag  = 40'((r < 0) ? -r : r);
      prod = 80'(mag) * 80'(mag);
      return prod[79:16];
   endfunction

   function automatic void push_gradient(input int step, input int joint, input longint g);
      scg_result_type item;
      item                = '0;
      item.step_index     = step[STEP_W-1:0];
      item.joint_index    = joint[JOINT_W-1:0];
      item.gradient_value = g[GRAD_W-1:0];
      awaited_results.push_back(item);
   endfunction

   // Works out what one accepted sample releases, in order: from step 2 on its own
   // gradient two steps back, then on the final sample the flush of the last two steps
   // for every joint, then the cost.
   function automatic void compute_gradients(input logic signed [POS_W-1:0] pos);
      int             nj;
      int             ns;
      int             t;
      int             j;
      longint         x;
      longint         r;
      longint         g;
      longint         p1;
      longint         p2;
      longint         q1;
      longint         q2;
      logic [63:0]    sq;
      scg_result_type item;

      // Out-of-range counts are clamped into the block's capacity.
      nj = (cfg_joints == 0) ? 1 : (cfg_joints > MAX_JOINTS) ? MAX_JOINTS : int'(cfg_joints);
      ns = (cfg_steps == 0) ? 1 : (cfg_steps > MAX_STEPS) ? MAX_STEPS : int'(cfg_steps);
      t  = step_count;
      j  = (joint_count >= nj) ? nj - 1 : joint_count;
      x  = longint'(pos);
      p1 = last_position[j];
      p2 = older_position[j];
      q1 = last_residual[j];
      q2 = older_residual[j];

      if (t == 0) begin
         r = 0;
      end else if (t == 1) begin
         r = x - p1;
      end else begin
         r = x - 2 * p1 + p2;
      end

      sq = square_q16(r);
      if (sq > COST_CEILING - cost_total) begin
         cost_total = COST_CEILING;
      end else begin
         cost_total = cost_total + sq;
      end

      if (t >= 2) begin
         g = (t == 2) ? 2 * (r - q1) : 2 * (q2 - 2 * q1 + r);
         push_gradient(t - 2, j, g);
      end

      older_position[j] = p1;
      last_position[j]  = x;
      older_residual[j] = q1;
      last_residual[j]  = r;

      if (j + 1 >= nj && t + 1 >= ns) begin
         if (t >= 1) begin
            for (int k = 0; k < nj; k++) begin
               g = (t == 1) ? -2 * last_residual[k]
                            : 2 * (older_residual[k] - 2 * last_residual[k]);
               push_gradient(t - 1, k, g);
            end
         end
         for (int k = 0; k < nj; k++) begin
            g = (t == 0) ? 0 : 2 * last_residual[k];
            push_gradient(t, k, g);
         end
         item            = '0;
         item.is_cost    = 1'b1;
         item.cost_value = cost_total[COST_W-1:0];
         item.last       = 1'b1;
         awaited_results.push_back(item);
         clear_model();
      end else if (j + 1 >= nj) begin
         joint_count = 0;
         step_count  = t + 1;
      end else begin
         joint_count = j + 1;
      end
   endfunction

   // ---------------------------------------------------------------------
   // Monitor: everything is sampled at the rising edge; the bench changes
   // its inputs only at the falling edge.
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      scg_result_type    got;
      scg_result_type    want;
      scg_result_type    tail;
      cost_override_type override;
      logic              bad;

      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got.is_cost        = rsp_is_cost;
            got.step_index     = rsp_step_index;
            got.joint_index    = rsp_joint_index;
            got.gradient_value = rsp_gradient_value;
            got.cost_value     = rsp_cost_value;
            got.last           = rsp_last;
            if (rsp_is_cost) begin
               costs_seen++;
            end else begin
               gradients_seen++;
            end
            if (awaited_results.size() == 0) begin
               failures++;
               if (failures <= 10) begin
                  $display("%0t: result transfer with nothing awaited: cost=%b step=%0d",
                           $realtime, got.is_cost, got.step_index);
               end
            end else begin
               want = awaited_results.pop_front();
               bad  = (got.is_cost !== want.is_cost) || (got.step_index !== want.step_index)
                   || (got.joint_index !== want.joint_index)
                   || (got.gradient_value !== want.gradient_value)
                   || (got.cost_value !== want.cost_value) || (got.last !== want.last);
               if (bad) begin
                  failures++;
                  if (failures <= 10) begin
                     $display({"%0t: mismatch, expected cost=%b step=%0d joint=%0d",
                               " grad=%h total=%h last=%b"},
                              $realtime, want.is_cost, want.step_index, want.joint_index,
                              want.gradient_value, want.cost_value, want.last);
                     $display({"%0t:           actual cost=%b step=%0d joint=%0d",
                               " grad=%h total=%h last=%b"},
                              $realtime, got.is_cost, got.step_index, got.joint_index,
                              got.gradient_value, got.cost_value, got.last);
                  end
               end
            end
         end

         // Any register write abandons the trajectory in progress.
         if (csr_write_enable) begin
            if (csr_index == CSR_NUM_JOINTS) begin
               cfg_joints = csr_write_data[CFG_JOINTS_W-1:0];
            end else begin
               cfg_steps = csr_write_data;
            end
            clear_model();
         end

         if (req_valid && req_ready) begin
            samples_taken++;
            override = cost_override_q.pop_front();
            compute_gradients(req_position);
            if (override.typed) begin
               tail            = awaited_results.pop_back();
               tail.cost_value = override.cost;
               awaited_results.push_back(tail);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: random back-pressure, calm stretches and one long hold-off.
   // ---------------------------------------------------------------------

   initial begin
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // Watchdog: a run that stops moving is a failure.
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_enable) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("%0t: no transfer for %0d cycles, %0d results still awaited",
               $realtime, WATCHDOG_LIMIT, awaited_results.size());
      $display("Simulation FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Sender
   // ---------------------------------------------------------------------

   // Offers one sample and returns once it has been accepted. Valid stays
   // high into the next sample unless an idle gap is drawn.
   task automatic send_sample(input logic [POS_W-1:0] pos, input logic typed,
                              input logic [COST_W-1:0] cost);
      cost_override_type override;
      @(negedge clock);
      while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      override.typed = typed;
      override.cost  = cost;
      cost_override_q.push_back(override);
      req_valid    <= 1'b1;
      req_position <= pos;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
   endtask

   // Stops sending and waits until every awaited result has come and the
   // block has had time to finish a sample that releases nothing.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      register_writes++;
   endtask

   function automatic stim_row_type sample_row(input logic [POS_W-1:0] pos,
                                               input logic typed,
                                               input logic [COST_W-1:0] cost);
      stim_row_type row;
      row            = '0;
      row.kind       = ROW_SAMPLE;
      row.position   = pos;
      row.typed      = typed;
      row.typed_cost = cost;
      return row;
   endfunction

   function automatic stim_row_type write_row(input csr_index_type idx,
                                              input logic [CSR_DATA_W-1:0] value);
      stim_row_type row;
      row           = '0;
      row.kind      = ROW_WRITE;
      row.reg_index = idx;
      row.reg_value = value;
      return row;
   endfunction

   // One random phase: new register values, then samples with random content.
   // A squeeze phase starts with the receiver held off so that the block fills
   // and stalls its input; pause_at, when non-zero, makes the sender wait for
   // every awaited result part-way through.
   task automatic run_phase(input logic [CFG_JOINTS_W-1:0] joints_raw,
                            input logic [CFG_STEPS_W-1:0] steps_raw, input int items,
                            input bit calm_phase, input bit squeeze, input int pause_at);
      logic [POS_W-1:0] pos;
      settle();
      write_register(CSR_NUM_JOINTS, CSR_DATA_W'(joints_raw));
      write_register(CSR_NUM_STEPS, steps_raw);
      calm = calm_phase;
      if (squeeze) begin
         hold_request = 1'b1;
      end
      for (int n = 0; n < items; n++) begin
         if (pause_at > 0 && n == pause_at) begin
            settle();
         end
         case ($urandom_range(9))
            0:       pos = 32'h7FFF_FFFF;
            1:       pos = 32'h8000_0000;
            2, 3, 4: pos = $urandom;
            // Mostly smooth motion within two units of the origin.
            default: pos = $urandom_range(32'h0004_0000) - 32'h0002_0000;
         endcase
         send_sample(pos, 1'b0, '0);
      end
      calm = 1'b0;
   endtask

   initial begin
      row_kind_type prev_kind;
      int           rj;
      int           rt;

      cfg_joints = JOINTS_RESET;
      cfg_steps  = STEPS_RESET;
      clear_model();

      // The trajectory of the reset values: seven joints, two steps. Every
      // joint moves by exactly one unit, so each step-1 residual squares to one unit
      // and the cost is seven units.
      for (int k = 0; k < 7; k++) begin
         directed_rows.push_back(sample_row(32'h0000_0000, 1'b0, '0));
      end
      for (int k = 0; k < 7; k++) begin
         directed_rows.push_back(sample_row(32'h0001_0000, k == 6, 63'h7_0000));
      end
      // Extreme positions on one joint over three steps.
      directed_rows.push_back(write_row(CSR_NUM_JOINTS, 11'd1));
      directed_rows.push_back(write_row(CSR_NUM_STEPS, 11'd3));
      directed_rows.push_back(sample_row(32'h7FFF_FFFF, 1'b0, '0));
      directed_rows.push_back(sample_row(32'h8000_0000, 1'b0, '0));
      directed_rows.push_back(sample_row(32'h7FFF_FFFF, 1'b0, '0));
      // Zero counts act as one: a single sample is a whole trajectory with
      // no residual, hence no cost.
      directed_rows.push_back(write_row(CSR_NUM_JOINTS, 11'd0));
      directed_rows.push_back(write_row(CSR_NUM_STEPS, 11'd0));
      directed_rows.push_back(sample_row(32'h1234_5678, 1'b1, '0));
      // A joint count above the capacity acts as eight; one step, no cost.
      directed_rows.push_back(write_row(CSR_NUM_JOINTS, 11'd15));
      directed_rows.push_back(write_row(CSR_NUM_STEPS, 11'd1));
      for (int k = 0; k < 8; k++) begin
         directed_rows.push_back(sample_row(k[0] ? 32'h8000_0000 : 32'h7FFF_FFFF,
                                            k == 7, '0));
      end
      // A trajectory that the first random phase's write cuts short.
      directed_rows.push_back(write_row(CSR_NUM_JOINTS, 11'd2));
      directed_rows.push_back(write_row(CSR_NUM_STEPS, 11'd4));
      directed_rows.push_back(sample_row(32'hFFFF_0000, 1'b0, '0));
      directed_rows.push_back(sample_row(32'h0000_8000, 1'b0, '0));

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      prev_kind = ROW_WRITE;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            if (prev_kind == ROW_SAMPLE) begin
               settle();
            end
            write_register(directed_rows[i].reg_index, directed_rows[i].reg_value);
         end else begin
            send_sample(directed_rows[i].position, directed_rows[i].typed,
                        directed_rows[i].typed_cost);
         end
         prev_kind = directed_rows[i].kind;
      end

      // Random phases: a calm stretch, a squeeze with the receiver held off,
      // a sender pause mid-trajectory ending in an aborted trajectory, a step
      // count above the capacity cut short by the next write, one-step
      // trajectories, a zero joint count and a random setting.
      run_phase(4'd3, 11'd4, 24, 1'b1, 1'b0, 0);
      run_phase(4'd8, 11'd3, 24, 1'b0, 1'b1, 0);
      run_phase(4'd2, 11'd5, 13, 1'b0, 1'b0, 7);
      run_phase(4'd1, 11'd2047, 12, 1'b0, 1'b0, 0);
      run_phase(4'd5, 11'd1, 10, 1'b0, 1'b0, 0);
      run_phase(4'd0, 11'd6, 12, 1'b0, 1'b0, 0);
      rj = $urandom_range(1, MAX_JOINTS);
      rt = $urandom_range(2, 4);
      run_phase(CFG_JOINTS_W'(rj), CFG_STEPS_W'(rt), rj * rt, 1'b0, 1'b0, 0);
      settle();

      $display("Run covered %0d samples, %0d gradient and %0d cost transfers, %0d register writes",
               samples_taken, gradients_seen, costs_seen, register_writes);
      $display("including clamped counts, stalls and aborted trajectories; %0d failures",
               failures);
      if (failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+design
design/scg_pkg.sv
design/scg_ctrl.sv
design/scg_dpath.sv
design/smoothness_cost_gradient_top.sv
tb/testbench.sv
